[hw/rtl/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes for the i2c master event sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

  // input item kinds
  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_RECV  = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // result actions
  localparam logic [2:0] ACT_STATUS  = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_STOP    = 3'd2;
  localparam logic [2:0] ACT_WRITE   = 3'd3;
  localparam logic [2:0] ACT_DELIVER = 3'd4;
  localparam logic [2:0] ACT_SET_ACK = 3'd5;
  localparam logic [2:0] ACT_NOTIFY  = 3'd6;
  localparam logic [2:0] ACT_CLR_ADDR = 3'd7;

  // notify codes
  localparam logic [7:0] NTF_TX_DONE   = 8'd0;
  localparam logic [7:0] NTF_RX_DONE   = 8'd1;
  localparam logic [7:0] NTF_STOP_DET  = 8'd2;
  localparam logic [7:0] NTF_ERR_BASE  = 8'd3;
  localparam logic [7:0] NTF_SLAVE_REQ = 8'd8;
  localparam logic [7:0] NTF_SLAVE_RCV = 8'd9;

  // status flag bit positions
  localparam int unsigned FLG_SB    = 0;
  localparam int unsigned FLG_ADDR  = 1;
  localparam int unsigned FLG_BTF   = 2;
  localparam int unsigned FLG_STOPF = 3;
  localparam int unsigned FLG_TXE   = 4;
  localparam int unsigned FLG_RXNE  = 5;
  localparam int unsigned FLG_BERR  = 6;
  localparam int unsigned NUM_ERR_FLAGS = 5;

  // transfer modes
  localparam logic [1:0] MODE_READY   = 2'd0;
  localparam logic [1:0] MODE_BUSY_RX = 2'd1;
  localparam logic [1:0] MODE_BUSY_TX = 2'd2;

  localparam int unsigned NUM_SLOTS = 12;
  localparam int unsigned JOB_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  slave_addr;
    logic [7:0]  length;
    logic        keep_bus;
    logic [10:0] event_flags;
    logic        is_master;
    logic        is_transmitter;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] value;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] value;
  } slot_t;

  // one classified item: fixed result slots in emission order
  typedef struct packed {
    logic [NUM_SLOTS-1:0]        valid;
    slot_t [NUM_SLOTS-1:0]       slots;
  } job_t;

endpackage

`default_nettype wire

[hw/rtl/i2c_master_event_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_master_event_sequencer
// Interrupt-driven i2c master transfer sequencer, queue-style ports both sides.
// ----------------------------------------------------------------------------
// Items (begin send, begin receive, event interrupt, error interrupt) enter
// through push/full and the resulting bus actions leave through empty/pop,
// oldest first, with last marking the final beat of each item. An item is
// taken in the cycle it is pushed whenever the two-entry job queue has room,
// so items may arrive back to back; the front updates the transfer state at
// that edge and files the item's actions as one job. The back drains jobs at
// one result beat per clock while pop keeps up, with no bubble between jobs;
// an item gives zero to eight results, the most for an event that closes a
// single-byte receive. Items with no results are not filed as a job. The
// output register lets a new item be taken while a finished beat still
// waits for pop. ack_enable may be rewritten only while the block is idle;
// it resets to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_event_sequencer #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // item side
  input  wire logic                 push,
  output logic                      full,
  input  wire i2cms_pkg::in_item_t  item_i,
  // result side
  output logic                      empty,
  input  wire logic                 pop,
  output i2cms_pkg::out_item_t      result_o,
  // ack_enable register
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_wdata_i
);

  // front to queue
  i2cms_pkg::job_t job_in;
  logic            job_push;
  logic            job_full;

  // queue to back
  i2cms_pkg::job_t job_out;
  logic            job_valid;
  logic            job_pop;

  // state keeper and classifier: one item per clock into the queue while it has room
  i2cms_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (item_i),
    .full_o      (full),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_o       (job_in),
    .job_push_o  (job_push),
    .job_full_i  (job_full)
  );

  // decouples item acceptance from result drain
  i2cms_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_push),
    .wdata_i (job_in),
    .full_o  (job_full),
    .rd_i    (job_pop),
    .valid_o (job_valid),
    .rdata_o (job_out)
  );

  // result serializer, one beat per clock unless pop stalls
  i2cms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

[hw/rtl/i2cms_front.sv]
// ----------------------------------------------------------------------------
// i2cms_front
// Accepts items, steps the transfer state and classifies each item into a job.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cms_front #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire i2cms_pkg::in_item_t item_i,
  output logic                    full_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  output i2cms_pkg::job_t         job_o,
  output logic                    job_push_o,
  input  wire logic               job_full_i
);

  // slot positions within a job
  localparam int unsigned S_SB     = 0;
  localparam int unsigned S_ADDR_ACK = 1;
  localparam int unsigned S_ADDR_CLR = 2;
  localparam int unsigned S_BTF_STOP = 3;
  localparam int unsigned S_BTF_NTF  = 4;
  localparam int unsigned S_STOPF  = 5;
  localparam int unsigned S_TXE    = 6;
  localparam int unsigned S_RX_ACK = 7;
  localparam int unsigned S_RX_DATA = 8;
  localparam int unsigned S_RX_STOP = 9;
  localparam int unsigned S_RX_ACK1 = 10;
  localparam int unsigned S_RX_NTF  = 11;

  logic                   ack_en_q;
  logic [1:0]             mode_q, mode_d;
  logic [COUNT_WIDTH-1:0] left_q, left_d;
  logic [COUNT_WIDTH-1:0] rx_total_q, rx_total_d;
  logic [6:0]             peer_q, peer_d;
  logic                   hold_q, hold_d;
  logic                   ev_on_q, ev_on_d;
  logic                   buf_on_q, buf_on_d;
  logic                   err_on_q, err_on_d;

  logic        accept;
  logic [10:0] fl;
  logic        ev, bufen;

  assign accept = push_i && !job_full_i;
  assign full_o = job_full_i;
  assign fl     = item_i.event_flags;
  assign ev     = ev_on_q;
  assign bufen  = buf_on_q;

  function automatic i2cms_pkg::slot_t mk(logic [2:0] act, logic [7:0] val);
    i2cms_pkg::slot_t s;
    s.action = act;
    s.value  = val;
    return s;
  endfunction

  always_comb begin
    mode_d     = mode_q;
    left_d     = left_q;
    rx_total_d = rx_total_q;
    peer_d     = peer_q;
    hold_d     = hold_q;
    ev_on_d    = ev_on_q;
    buf_on_d   = buf_on_q;
    err_on_d   = err_on_q;
    job_o      = '0;

    unique case (item_i.kind) inside
      i2cms_pkg::KIND_SEND, i2cms_pkg::KIND_RECV: begin
        if (mode_q != i2cms_pkg::MODE_BUSY_RX && mode_q != i2cms_pkg::MODE_BUSY_TX) begin
          left_d = COUNT_WIDTH'(item_i.length);
          if (item_i.kind == i2cms_pkg::KIND_RECV) begin
            mode_d     = i2cms_pkg::MODE_BUSY_RX;
            rx_total_d = COUNT_WIDTH'(item_i.length);
          end else begin
            mode_d = i2cms_pkg::MODE_BUSY_TX;
          end
          peer_d   = item_i.slave_addr;
          hold_d   = item_i.keep_bus;
          ev_on_d  = 1'b1;
          buf_on_d = 1'b1;
          err_on_d = 1'b1;
          job_o.valid[0] = 1'b1;
          job_o.slots[0] = mk(i2cms_pkg::ACT_START, 8'd0);
        end
        job_o.valid[1] = 1'b1;
        job_o.slots[1] = mk(i2cms_pkg::ACT_STATUS, {6'd0, mode_q});
      end

      i2cms_pkg::KIND_EVENT: begin
        // address byte with r/w bit
        if (ev && fl[i2cms_pkg::FLG_SB]) begin
          if (mode_q == i2cms_pkg::MODE_BUSY_TX) begin
            job_o.valid[S_SB] = 1'b1;
            job_o.slots[S_SB] = mk(i2cms_pkg::ACT_WRITE, {peer_q, 1'b0});
          end else if (mode_q == i2cms_pkg::MODE_BUSY_RX) begin
            job_o.valid[S_SB] = 1'b1;
            job_o.slots[S_SB] = mk(i2cms_pkg::ACT_WRITE, {peer_q, 1'b1});
          end
        end
        if (ev && fl[i2cms_pkg::FLG_ADDR]) begin
          // single-byte receive drops ack before address clear
          if (item_i.is_master && mode_q == i2cms_pkg::MODE_BUSY_RX &&
              rx_total_q == COUNT_WIDTH'(1)) begin
            job_o.valid[S_ADDR_ACK] = 1'b1;
            job_o.slots[S_ADDR_ACK] = mk(i2cms_pkg::ACT_SET_ACK, 8'd0);
          end
          job_o.valid[S_ADDR_CLR] = 1'b1;
          job_o.slots[S_ADDR_CLR] = mk(i2cms_pkg::ACT_CLR_ADDR, 8'd0);
        end
        // transmit close
        if (ev && fl[i2cms_pkg::FLG_BTF] && mode_q == i2cms_pkg::MODE_BUSY_TX &&
            fl[i2cms_pkg::FLG_TXE] && left_q == '0) begin
          if (!hold_q) begin
            job_o.valid[S_BTF_STOP] = 1'b1;
            job_o.slots[S_BTF_STOP] = mk(i2cms_pkg::ACT_STOP, 8'd0);
          end
          job_o.valid[S_BTF_NTF] = 1'b1;
          job_o.slots[S_BTF_NTF] = mk(i2cms_pkg::ACT_NOTIFY, i2cms_pkg::NTF_TX_DONE);
          buf_on_d = 1'b0;
          ev_on_d  = 1'b0;
          mode_d   = i2cms_pkg::MODE_READY;
          left_d   = '0;
        end
        if (ev && fl[i2cms_pkg::FLG_STOPF]) begin
          job_o.valid[S_STOPF] = 1'b1;
          job_o.slots[S_STOPF] = mk(i2cms_pkg::ACT_NOTIFY, i2cms_pkg::NTF_STOP_DET);
        end
        if (ev && bufen && fl[i2cms_pkg::FLG_TXE]) begin
          if (item_i.is_master) begin
            if (mode_d == i2cms_pkg::MODE_BUSY_TX && left_d != '0) begin
              job_o.valid[S_TXE] = 1'b1;
              job_o.slots[S_TXE] = mk(i2cms_pkg::ACT_WRITE, item_i.tx_byte);
              left_d = left_d - COUNT_WIDTH'(1);
            end
          end else if (item_i.is_transmitter) begin
            job_o.valid[S_TXE] = 1'b1;
            job_o.slots[S_TXE] = mk(i2cms_pkg::ACT_NOTIFY, i2cms_pkg::NTF_SLAVE_REQ);
          end
        end
        if (ev && bufen && fl[i2cms_pkg::FLG_RXNE]) begin
          if (item_i.is_master) begin
            if (mode_d == i2cms_pkg::MODE_BUSY_RX) begin
              if (rx_total_q != '0) begin
                // ack drop at two bytes left
                if (rx_total_q != COUNT_WIDTH'(1) && left_d == COUNT_WIDTH'(2)) begin
                  job_o.valid[S_RX_ACK] = 1'b1;
                  job_o.slots[S_RX_ACK] = mk(i2cms_pkg::ACT_SET_ACK, 8'd0);
                end
                job_o.valid[S_RX_DATA] = 1'b1;
                job_o.slots[S_RX_DATA] = mk(i2cms_pkg::ACT_DELIVER, item_i.rx_byte);
                if (left_d != '0) begin
                  left_d = left_d - COUNT_WIDTH'(1);
                end
              end
              // receive close
              if (left_d == '0) begin
                if (!hold_q) begin
                  job_o.valid[S_RX_STOP] = 1'b1;
                  job_o.slots[S_RX_STOP] = mk(i2cms_pkg::ACT_STOP, 8'd0);
                end
                if (ack_en_q) begin
                  job_o.valid[S_RX_ACK1] = 1'b1;
                  job_o.slots[S_RX_ACK1] = mk(i2cms_pkg::ACT_SET_ACK, 8'd1);
                end
                job_o.valid[S_RX_NTF] = 1'b1;
                job_o.slots[S_RX_NTF] = mk(i2cms_pkg::ACT_NOTIFY, i2cms_pkg::NTF_RX_DONE);
                buf_on_d   = 1'b0;
                ev_on_d    = 1'b0;
                mode_d     = i2cms_pkg::MODE_READY;
                left_d     = '0;
                rx_total_d = '0;
              end
            end
          end else if (!item_i.is_transmitter) begin
            job_o.valid[S_RX_ACK] = 1'b1;
            job_o.slots[S_RX_ACK] = mk(i2cms_pkg::ACT_NOTIFY, i2cms_pkg::NTF_SLAVE_RCV);
          end
        end
      end

      default: begin
        // error flags, one notify each, lowest bit first
        if (err_on_q) begin
          for (int i = 0; i < int'(i2cms_pkg::NUM_ERR_FLAGS); i++) begin
            if (fl[int'(i2cms_pkg::FLG_BERR) + i]) begin
              job_o.valid[i] = 1'b1;
              job_o.slots[i] = mk(i2cms_pkg::ACT_NOTIFY,
                                  i2cms_pkg::NTF_ERR_BASE + 8'(i));
            end
          end
        end
      end
    endcase
  end

  assign job_push_o = accept && (job_o.valid != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_en_q   <= 1'b1;
      mode_q     <= i2cms_pkg::MODE_READY;
      left_q     <= '0;
      rx_total_q <= '0;
      peer_q     <= '0;
      hold_q     <= 1'b0;
      ev_on_q    <= 1'b0;
      buf_on_q   <= 1'b0;
      err_on_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ack_en_q <= cfg_wdata_i;
      end
      if (accept) begin
        mode_q     <= mode_d;
        left_q     <= left_d;
        rx_total_q <= rx_total_d;
        peer_q     <= peer_d;
        hold_q     <= hold_d;
        ev_on_q    <= ev_on_d;
        buf_on_q   <= buf_on_d;
        err_on_q   <= err_on_d;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/i2cms_job_fifo.sv]
// ----------------------------------------------------------------------------
// i2cms_job_fifo
// Short queue of classified jobs between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cms_job_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire i2cms_pkg::job_t  wdata_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic                  valid_o,
  output i2cms_pkg::job_t       rdata_o
);

  localparam int unsigned PW = $clog2(i2cms_pkg::JOB_DEPTH);

  i2cms_pkg::job_t mem [i2cms_pkg::JOB_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          do_wr, do_rd;

  assign full_o  = cnt_q == (PW+1)'(i2cms_pkg::JOB_DEPTH);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem[rp_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == PW'(i2cms_pkg::JOB_DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (do_rd) begin
        rp_q <= (rp_q == PW'(i2cms_pkg::JOB_DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/i2cms_back.sv]
// ----------------------------------------------------------------------------
// i2cms_back
// Walks each job's valid slots, one result beat per cycle while pop keeps up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cms_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             job_valid_i,
  input  wire i2cms_pkg::job_t  job_i,
  output logic                  job_pop_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output i2cms_pkg::out_item_t  result_o
);

  localparam int unsigned N = i2cms_pkg::NUM_SLOTS;

  logic [N-1:0]                 mask_q, mask_d;
  i2cms_pkg::slot_t [N-1:0]     slots_q;
  logic                         out_valid_q;
  i2cms_pkg::out_item_t         out_q;

  logic [N-1:0]      pick, rest, mask_after;
  i2cms_pkg::slot_t  sel;
  logic              issue, load;

  // lowest pending slot
  assign pick = mask_q & (~mask_q + N'(1));
  assign rest = mask_q & ~pick;

  always_comb begin
    sel = '0;
    for (int i = 0; i < int'(N); i++) begin
      if (pick[i]) begin
        sel = slots_q[i];
      end
    end
  end

  assign issue      = (mask_q != '0) && (!out_valid_q || pop_i);
  assign mask_after = issue ? rest : mask_q;
  assign load       = (mask_after == '0) && job_valid_i;
  assign mask_d     = load ? job_i.valid : mask_after;
  assign job_pop_o  = load;
  assign empty_o    = !out_valid_q;
  assign result_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      slots_q <= job_i.slots;
    end
    if (issue) begin
      out_q.action <= sel.action;
      out_q.value  <= sel.value;
      out_q.last   <= rest == '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb_i2cms_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// tb_i2cms_scoreboard_pkg
// Bus action predictor and in-order result checker for the sequencer bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tb_i2cms_scoreboard_pkg;

  import i2cms_pkg::*;

  class bus_action_scoreboard;

    // predicted transfer state
    logic       ack_en;
    logic [1:0] mode;
    logic [7:0] bytes_to_go;
    logic [7:0] rx_total;
    logic [6:0] peer;
    logic       hold;
    logic       ev_on;
    logic       buf_on;
    logic       err_on;

    out_item_t expected_actions[$];
    out_item_t batch[$];

    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned items_noted;
    int unsigned tx_closed;
    int unsigned rx_closed;

    function new();
      ack_en      = 1'b1;
      mode        = MODE_READY;
      bytes_to_go = '0;
      rx_total    = '0;
      peer        = '0;
      hold        = 1'b0;
      ev_on       = 1'b0;
      buf_on      = 1'b0;
      err_on      = 1'b0;
    endfunction

    function void set_ack_enable(logic v);
      ack_en = v;
    endfunction

    function int outstanding();
      return expected_actions.size();
    endfunction

    function void add(logic [2:0] act, logic [7:0] val);
      out_item_t r;
      r.action = act;
      r.value  = val;
      r.last   = 1'b0;
      batch.push_back(r);
    endfunction

    // byte count saturates at zero
    function void count_down();
      if (bytes_to_go != 8'd0) bytes_to_go = bytes_to_go - 8'd1;
    endfunction

    function void receive_byte(logic [7:0] b);
      if (rx_total == 8'd1) begin
        add(ACT_DELIVER, b);
        count_down();
      end
      if (rx_total > 8'd1) begin
        if (bytes_to_go == 8'd2) add(ACT_SET_ACK, 8'd0);
        add(ACT_DELIVER, b);
        count_down();
      end
      if (bytes_to_go == 8'd0) begin
        if (!hold) add(ACT_STOP, 8'd0);
        buf_on      = 1'b0;
        ev_on       = 1'b0;
        mode        = MODE_READY;
        bytes_to_go = '0;
        rx_total    = '0;
        if (ack_en) add(ACT_SET_ACK, 8'd1);
        rx_closed++;
        add(ACT_NOTIFY, NTF_RX_DONE);
      end
    endfunction

    // enables are sampled once on entry, a close does not mask later flags
    function void event_actions(in_item_t it, logic ev, logic bf);
      logic [10:0] fl;
      fl = it.event_flags;
      if (ev && fl[FLG_SB]) begin
        if (mode == MODE_BUSY_TX) add(ACT_WRITE, {peer, 1'b0});
        else if (mode == MODE_BUSY_RX) add(ACT_WRITE, {peer, 1'b1});
      end
      if (ev && fl[FLG_ADDR]) begin
        if (it.is_master && mode == MODE_BUSY_RX && rx_total == 8'd1) add(ACT_SET_ACK, 8'd0);
        add(ACT_CLR_ADDR, 8'd0);
      end
      if (ev && fl[FLG_BTF] && fl[FLG_TXE] && mode == MODE_BUSY_TX && bytes_to_go == 8'd0) begin
        if (!hold) add(ACT_STOP, 8'd0);
        buf_on      = 1'b0;
        ev_on       = 1'b0;
        mode        = MODE_READY;
        bytes_to_go = '0;
        tx_closed++;
        add(ACT_NOTIFY, NTF_TX_DONE);
      end
      if (ev && fl[FLG_STOPF]) add(ACT_NOTIFY, NTF_STOP_DET);
      if (ev && bf && fl[FLG_TXE]) begin
        if (it.is_master) begin
          if (mode == MODE_BUSY_TX && bytes_to_go != 8'd0) begin
            add(ACT_WRITE, it.tx_byte);
            count_down();
          end
        end else if (it.is_transmitter) begin
          add(ACT_NOTIFY, NTF_SLAVE_REQ);
        end
      end
      if (ev && bf && fl[FLG_RXNE]) begin
        if (it.is_master) begin
          if (mode == MODE_BUSY_RX) receive_byte(it.rx_byte);
        end else if (!it.is_transmitter) begin
          add(ACT_NOTIFY, NTF_SLAVE_RCV);
        end
      end
    endfunction

    // predict the beats of one accepted item, returns how many
    function int note_item(in_item_t it);
      logic [1:0] prior;
      logic       ev;
      logic       bf;
      out_item_t  tail;
      batch.delete();
      items_noted++;
      ev = ev_on;
      bf = buf_on;
      case (it.kind)
        KIND_SEND, KIND_RECV: begin
          prior = mode;
          if (prior != MODE_BUSY_RX && prior != MODE_BUSY_TX) begin
            bytes_to_go = it.length;
            if (it.kind == KIND_RECV) begin
              mode     = MODE_BUSY_RX;
              rx_total = it.length;
            end else begin
              mode = MODE_BUSY_TX;
            end
            peer = it.slave_addr;
            hold = it.keep_bus;
            add(ACT_START, 8'd0);
            buf_on = 1'b1;
            ev_on  = 1'b1;
            err_on = 1'b1;
          end
          add(ACT_STATUS, {6'd0, prior});
        end
        KIND_EVENT: event_actions(it, ev, bf);
        default: begin
          if (err_on) begin
            for (int unsigned b = FLG_BERR; b < FLG_BERR + NUM_ERR_FLAGS; b++) begin
              if (it.event_flags[b]) add(ACT_NOTIFY, NTF_ERR_BASE + 8'(b - FLG_BERR));
            end
          end
        end
      endcase
      if (batch.size() != 0) begin
        tail = batch.pop_back();
        tail.last = 1'b1;
        batch.push_back(tail);
      end
      foreach (batch[i]) expected_actions.push_back(batch[i]);
      return batch.size();
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_beat(out_item_t got);
      out_item_t want;
      beats_checked++;
      if (expected_actions.size() == 0) begin
        report($sformatf("beat %0d unexpected, action %0d value %0d last %0b",
                         beats_checked, got.action, got.value, got.last));
        return;
      end
      want = expected_actions.pop_front();
      if (got.action !== want.action)
        report($sformatf("beat %0d action %0d, want %0d", beats_checked, got.action,
                         want.action));
      if (got.value !== want.value)
        report($sformatf("beat %0d value %0d, want %0d", beats_checked, got.value,
                         want.value));
      if (got.last !== want.last)
        report($sformatf("beat %0d last %0b, want %0b", beats_checked, got.last, want.last));
    endtask

  endclass

endpackage

[tb/sv/tb_i2c_master_event_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_i2c_master_event_sequencer
// Self-checking bench for the interrupt-driven i2c master sequencer.
// ----------------------------------------------------------------------------
// A directed opener walks through begin requests (accepted and refused),
// address phase, transmit and receive byte flow, stop versus kept bus,
// zero-length receive, slave notifications and error flags. Three random
// phases follow, after ack_enable writes of 0, 1 and 0, with stimulus
// steered by the predicted transfer state so most items are legal steps of
// a live transfer. Every result beat is checked against the predictor in
// order; the sender bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_i2c_master_event_sequencer;

  import i2cms_pkg::*;
  import tb_i2cms_scoreboard_pkg::*;

  // single-flag masks for building events
  localparam logic [10:0] F_SB      = 11'(1) << FLG_SB;
  localparam logic [10:0] F_ADDR    = 11'(1) << FLG_ADDR;
  localparam logic [10:0] F_BTF     = 11'(1) << FLG_BTF;
  localparam logic [10:0] F_STOPF   = 11'(1) << FLG_STOPF;
  localparam logic [10:0] F_TXE     = 11'(1) << FLG_TXE;
  localparam logic [10:0] F_RXNE    = 11'(1) << FLG_RXNE;
  localparam logic [10:0] F_ERR_ALL = 11'((1 << NUM_ERR_FLAGS) - 1) << FLG_BERR;
  localparam logic [10:0] F_ALL     = '1;

  logic      clk       = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      push      = 1'b0;
  logic      full;
  in_item_t  item_d    = '0;
  logic      empty;
  logic      pop       = 1'b0;
  out_item_t result_q;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  // dut outputs captured mid-cycle, used at the following rising edge
  logic      empty_seen  = 1'b1;
  out_item_t result_seen = '0;

  logic [15:0] pop_pattern = 16'hFFFF;
  int unsigned rx_cycle    = 0;

  bus_action_scoreboard action_sb = new();

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  i2c_master_event_sequencer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_d),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_q),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // nothing on the dut side moves at the falling edge, so this is race free
  always @(negedge clk) begin
    empty_seen  = empty;
    result_seen = result_q;
  end

  // result side: a beat moves when pop and not empty at the edge; pop then
  // follows a 16-bit mask stepped by rx_cycle and re-drawn as it runs, sometimes
  // all ones so there are stretches with no stall at all
  always @(posedge clk) begin
    if (rst_ni && pop && !empty_seen) action_sb.check_beat(result_seen);
    rx_cycle++;
    if (rx_cycle % 128 == 0)
      pop_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    pop <= pop_pattern[rx_cycle % 16];
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic in_item_t begin_req(logic [1:0] kind, logic [6:0] addr, logic [7:0] len,
                                         logic keep);
    in_item_t it;
    it = '0;
    it.kind       = kind;
    it.slave_addr = addr;
    it.length     = len;
    it.keep_bus   = keep;
    return it;
  endfunction

  function automatic in_item_t bus_event(logic [10:0] flags, logic master, logic trans,
                                         logic [7:0] tx, logic [7:0] rx);
    in_item_t it;
    it = '0;
    it.kind           = KIND_EVENT;
    it.event_flags    = flags;
    it.is_master      = master;
    it.is_transmitter = trans;
    it.tx_byte        = tx;
    it.rx_byte        = rx;
    return it;
  endfunction

  function automatic in_item_t error_irq(logic [10:0] flags);
    in_item_t it;
    it = '0;
    it.kind        = KIND_ERROR;
    it.event_flags = flags;
    return it;
  endfunction

  // random item shaped by the predicted transfer state: mostly legal next
  // steps of the current transfer, the rest noise and refused requests
  function automatic in_item_t pick_item();
    logic [63:0] raw;
    in_item_t    it;
    int unsigned roll;
    int unsigned step;
    raw  = {$urandom, $urandom};
    it   = raw[$bits(in_item_t)-1:0];
    roll = $urandom_range(0, 99);
    if (action_sb.mode != MODE_BUSY_TX && action_sb.mode != MODE_BUSY_RX) begin
      if (roll < 70) begin
        it.kind   = $urandom_range(0, 1) ? KIND_RECV : KIND_SEND;
        // short transfers keep the run brisk, a few longer ones for depth
        it.length = (roll < 4) ? 8'($urandom_range(8, 24)) : 8'($urandom_range(0, 5));
      end else begin
        it.kind = (roll < 85) ? KIND_EVENT : KIND_ERROR;
      end
    end else if (roll < 10) begin
      // raw noise, any kind
    end else if (roll < 18) begin
      it.kind = KIND_ERROR;
    end else if (roll < 24) begin
      it.kind = $urandom_range(0, 1) ? KIND_RECV : KIND_SEND;
    end else begin
      it.kind      = KIND_EVENT;
      it.is_master = 1'b1;
      step         = $urandom_range(0, 11);
      case (step)
        0: it.event_flags = F_SB;
        1: it.event_flags = F_ADDR;
        2: it.event_flags = F_STOPF;
        3: begin
          it.is_master   = 1'b0;
          it.event_flags = ($urandom_range(0, 1) ? F_TXE : 11'd0) |
                           ($urandom_range(0, 1) ? F_RXNE : 11'd0);
        end
        default: begin
          if (action_sb.mode == MODE_BUSY_TX)
            it.event_flags = (action_sb.bytes_to_go != 8'd0) ? F_TXE : (F_BTF | F_TXE);
          else
            it.event_flags = F_RXNE;
        end
      endcase
      if ($urandom_range(0, 9) == 0) it.event_flags |= 11'($urandom);
    end
    return it;
  endfunction

  // called at a rising edge; returns at the edge that took the item, with
  // push still high so the caller either sends again or lowers it there
  task automatic send_item(input in_item_t it, output int produced);
    logic taken;
    push   <= 1'b1;
    item_d <= it;
    taken  = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end
    produced = action_sb.note_item(it);
  endtask

  // let every predicted beat come out with push low; a guard bounds the wait
  task automatic wait_drained();
    int unsigned guard;
    push  <= 1'b0;
    guard = 0;
    while (action_sb.outstanding() != 0 && guard < 40000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ack(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    action_sb.set_ack_enable(v);
  endtask

  task automatic run_directed();
    int n;
    // nothing armed yet: event and error items give no beats
    send_item(bus_event(F_ALL, 1'b1, 1'b1, 8'hFF, 8'hFF), n);
    send_item(error_irq(F_ALL), n);
    // send two bytes to the top address, with a stop
    send_item(begin_req(KIND_SEND, 7'h7F, 8'd2, 1'b0), n);
    send_item(begin_req(KIND_RECV, 7'h00, 8'd255, 1'b1), n);    // refused while busy
    send_item(bus_event(F_SB, 1'b1, 1'b0, 8'h00, 8'h00), n);
    send_item(bus_event(F_ADDR, 1'b1, 1'b0, 8'h00, 8'h00), n);
    send_item(bus_event(F_TXE, 1'b1, 1'b1, 8'hFF, 8'h00), n);
    send_item(bus_event(F_TXE, 1'b1, 1'b1, 8'h00, 8'h00), n);
    send_item(bus_event(F_BTF | F_TXE, 1'b1, 1'b1, 8'h00, 8'h00), n);
    send_item(error_irq(F_ERR_ALL), n);
    // single-byte receive: ack dropped at address, bus kept
    send_item(begin_req(KIND_RECV, 7'h00, 8'd1, 1'b1), n);
    send_item(bus_event(F_SB, 1'b1, 1'b0, 8'h00, 8'h00), n);
    send_item(bus_event(F_ADDR, 1'b1, 1'b0, 8'h00, 8'h00), n);
    send_item(bus_event(F_RXNE, 1'b1, 1'b0, 8'h00, 8'hFF), n);
    // zero-length receive closes on the first rxne
    send_item(begin_req(KIND_RECV, 7'h55, 8'd0, 1'b0), n);
    send_item(bus_event(F_RXNE, 1'b1, 1'b0, 8'h00, 8'h00), n);
    // slave notifications during a transfer, then every flag at once
    send_item(begin_req(KIND_SEND, 7'h2A, 8'd1, 1'b1), n);
    send_item(bus_event(F_TXE | F_RXNE, 1'b0, 1'b1, 8'h00, 8'h00), n);
    send_item(bus_event(F_TXE | F_RXNE | F_STOPF, 1'b0, 1'b0, 8'h00, 8'h00), n);
    send_item(bus_event(F_ALL, 1'b1, 1'b0, 8'hAA, 8'h55), n);
    send_item(bus_event(F_BTF | F_TXE, 1'b1, 1'b0, 8'h00, 8'h00), n);
    // three-byte receive: ack drop at two left, stop, ack restore
    send_item(begin_req(KIND_RECV, 7'h03, 8'd3, 1'b0), n);
    send_item(bus_event(F_RXNE, 1'b1, 1'b0, 8'h00, 8'h5A), n);
    send_item(bus_event(F_RXNE, 1'b1, 1'b0, 8'h00, 8'hA5), n);
    send_item(bus_event(F_RXNE, 1'b1, 1'b0, 8'h00, 8'h3C), n);
  endtask

  // bursts of back-to-back items with random gaps; when asked, one pause
  // halfway lets the result side run completely dry
  task automatic run_random(input int unsigned goal, input bit pause_once);
    int unsigned made;
    int unsigned burst;
    int unsigned gap;
    int          n;
    bit          paused;
    made   = 0;
    paused = 1'b0;
    while (made < goal) begin
      burst = $urandom_range(1, 10);
      for (int unsigned k = 0; k < burst && made < goal; k++) begin
        send_item(pick_item(), n);
        made++;
      end
      if (pause_once && !paused && made >= goal / 2) begin
        paused = 1'b1;
        wait_drained();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // ack_enable left at its reset value for the opener
    run_directed();

    wait_drained();
    write_ack(1'b0);
    run_random(52, 1'b0);

    wait_drained();
    write_ack(1'b1);
    run_random(52, 1'b1);

    wait_drained();
    write_ack(1'b0);
    run_random(51, 1'b0);

    wait_drained();
    repeat (16) @(posedge clk);

    if (action_sb.outstanding() != 0)
      action_sb.report($sformatf("%0d expected beats never arrived", action_sb.outstanding()));

    $display("run covered %0d items and %0d beats, %0d sends and %0d receives completed",
             action_sb.items_noted, action_sb.beats_checked, action_sb.tx_closed,
             action_sb.rx_closed);
    $display("ack_enable exercised at 1, 0, 1, 0 with %0d mismatches", action_sb.mismatches);
    if (action_sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
